/* hw/rtl/rpfa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpfa_pkg: shared definitions for the page frame allocator
// Sizes, operation codes, status codes and the count update result type.
// ----------------------------------------------------------------------------
package rpfa_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int PAGE_W    = 12;
    localparam int FREE_W    = 13;
    localparam int COUNT_W   = 8;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
    localparam logic [OP_W-1:0] OP_INC    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEC    = 3'd3;
    localparam logic [OP_W-1:0] OP_GET    = 3'd4;
    localparam logic [OP_W-1:0] OP_DONATE = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd3;

    // result of the shared count update unit
    typedef struct packed {
        logic [COUNT_W-1:0] count;      // count to write back
        logic               was_zero;   // count read was zero
        logic               saturated;  // inc hit the maximum
    } cnt_res_t;

endpackage
`default_nettype wire

/* hw/rtl/rpfa_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpfa_ram: generic simple dual port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpfa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/rpfa_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rpfa_alu: reference count update unit
// One incrementer/decrementer with saturation, shared by all count operations.
// ----------------------------------------------------------------------------
module rpfa_alu (
    input  wire logic [rpfa_pkg::OP_W-1:0]    op,
    input  wire logic [rpfa_pkg::COUNT_W-1:0] count_in,
    output rpfa_pkg::cnt_res_t                res
);

    logic is_zero;
    logic is_max;

    assign is_zero = (count_in == '0);
    assign is_max  = (count_in == rpfa_pkg::COUNT_MAX);

    always_comb begin
        res.count     = count_in;
        res.was_zero  = is_zero;
        res.saturated = 1'b0;
        unique case (op)
            rpfa_pkg::OP_FREE, rpfa_pkg::OP_DEC: begin
                if (!is_zero) begin
                    res.count = count_in - rpfa_pkg::COUNT_W'(1);
                end
            end
            rpfa_pkg::OP_INC: begin
                if (is_max) begin
                    res.saturated = 1'b1;
                end else begin
                    res.count = count_in + rpfa_pkg::COUNT_W'(1);
                end
            end
            rpfa_pkg::OP_DONATE: begin
                res.count = '0;
            end
            default: begin
                res.count = count_in;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/refcounted_page_frame_allocator_top.sv */
`default_nettype none
// Results are registered: an accepted transaction moves the sequencer from IDLE
// to EXEC, which loads the result register; EXEC waits while an earlier result
// waits for m_ready. A new transaction is taken only in IDLE, after the last
// one completes: IDLE issues the count table / free stack reads, EXEC writes back.
// Reset: after aresetn the count table is cleared by a pass over every entry,
// one entry per cycle, with s_ready low; cfg writes are accepted throughout.
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_top: page frame allocator with ref counts
// LIFO free page stack plus a per page reference count table, driven by a
// small sequencer around a shared count update unit.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input transactions
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [rpfa_pkg::OP_W-1:0]       s_operation,
    input  wire logic [rpfa_pkg::PAGE_W-1:0]     s_page_number,
    // result transactions
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [rpfa_pkg::PAGE_W-1:0]     m_page_out,
    output logic      [rpfa_pkg::COUNT_W-1:0]    m_count_out,
    output logic      [rpfa_pkg::FREE_W-1:0]     m_free_pages,
    output logic                                 m_released,
    output logic      [rpfa_pkg::STATUS_W-1:0]   m_status,
    // configuration (first_page)
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rpfa_pkg::PAGE_W-1:0]     cfg_data
);

    localparam logic [rpfa_pkg::FREE_W-1:0] FULL_LEVEL = rpfa_pkg::FREE_W'(rpfa_pkg::NUM_PAGES);

    typedef enum logic [1:0] {
        CLEAR,  // post reset sweep of the count table
        IDLE,   // waiting for an input transaction, RAM reads issued
        EXEC    // read data back, compute, write back, load result
    } state_t;

    state_t state_reg;

    // captured transaction
    logic [rpfa_pkg::OP_W-1:0]   op_reg;
    logic [rpfa_pkg::PAGE_W-1:0] pg_reg;

    // architectural state
    logic [rpfa_pkg::PAGE_W-1:0] first_page_reg;
    logic [rpfa_pkg::FREE_W-1:0] free_top_reg;
    logic [rpfa_pkg::PAGE_W-1:0] clr_addr_reg;

    // result register
    logic                          m_valid_reg;
    logic [rpfa_pkg::PAGE_W-1:0]   m_page_reg;
    logic [rpfa_pkg::COUNT_W-1:0]  m_count_reg;
    logic [rpfa_pkg::FREE_W-1:0]   m_free_reg;
    logic                          m_released_reg;
    logic [rpfa_pkg::STATUS_W-1:0] m_status_reg;

    // RAM ports
    logic [rpfa_pkg::COUNT_W-1:0] cnt_rd;
    logic [rpfa_pkg::PAGE_W-1:0]  cnt_raddr;
    logic                         cnt_we;
    logic [rpfa_pkg::PAGE_W-1:0]  cnt_waddr;
    logic [rpfa_pkg::COUNT_W-1:0] cnt_wdata;
    logic [rpfa_pkg::PAGE_W-1:0]  stk_rd;
    logic [rpfa_pkg::PAGE_W-1:0]  stk_raddr;
    logic                         stk_we;

    // execute stage decode
    rpfa_pkg::cnt_res_t           alu_res;
    logic                         s_fire;
    logic                         exec_go;
    logic                         in_range;
    logic                         stack_empty;
    logic                         stack_full;
    logic                         is_alloc;
    logic                         is_cnt_op;
    logic                         push_do;

    // next result values, taken when exec_go
    logic [rpfa_pkg::PAGE_W-1:0]   page_next;
    logic [rpfa_pkg::COUNT_W-1:0]  count_next;
    logic [rpfa_pkg::FREE_W-1:0]   free_next;
    logic                          released_next;
    logic [rpfa_pkg::STATUS_W-1:0] status_next;
    logic                          ex_cnt_we;
    logic [rpfa_pkg::PAGE_W-1:0]   ex_cnt_waddr;
    logic [rpfa_pkg::COUNT_W-1:0]  ex_cnt_wdata;

    assign s_ready   = (state_reg == IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // EXEC finishes only when the result register can take the result;
    // until then the RAM reads keep refreshing the same addresses.
    assign exec_go = (state_reg == EXEC) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    // In IDLE the count table is read at the incoming page so the data is
    // there in EXEC. The stack is always read at top-1 (the pop slot); top
    // only moves when EXEC completes.
    assign cnt_raddr = (state_reg == IDLE) ? s_page_number : pg_reg;
    assign stk_raddr = rpfa_pkg::PAGE_W'(free_top_reg - rpfa_pkg::FREE_W'(1));

    rpfa_ram #(
        .DEPTH (rpfa_pkg::NUM_PAGES),
        .WIDTH (rpfa_pkg::COUNT_W)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rd)
    );

    rpfa_ram #(
        .DEPTH (rpfa_pkg::NUM_PAGES),
        .WIDTH (rpfa_pkg::PAGE_W)
    ) u_stk_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (free_top_reg[rpfa_pkg::PAGE_W-1:0]),
        .wdata (pg_reg),
        .raddr (stk_raddr),
        .rdata (stk_rd)
    );

    // ------------------------------------------------------------------
    // Execute decode
    // ------------------------------------------------------------------
    rpfa_alu u_alu (
        .op       (op_reg),
        .count_in (cnt_rd),
        .res      (alu_res)
    );

    assign in_range    = (pg_reg >= first_page_reg) &&
                         ({1'b0, pg_reg} < FULL_LEVEL);
    assign stack_empty = (free_top_reg == '0);
    assign stack_full  = (free_top_reg == FULL_LEVEL);
    assign is_alloc    = (op_reg == rpfa_pkg::OP_ALLOC);
    assign is_cnt_op   = (op_reg == rpfa_pkg::OP_FREE) || (op_reg == rpfa_pkg::OP_INC) ||
                         (op_reg == rpfa_pkg::OP_DEC)  || (op_reg == rpfa_pkg::OP_GET) ||
                         (op_reg == rpfa_pkg::OP_DONATE);
    // free and donate push only a page whose count was zero; a full stack
    // silently drops the push
    assign push_do     = is_cnt_op && in_range && alu_res.was_zero && !stack_full &&
                         ((op_reg == rpfa_pkg::OP_FREE) || (op_reg == rpfa_pkg::OP_DONATE));

    always_comb begin
        page_next     = '0;
        count_next    = '0;
        free_next     = free_top_reg;
        released_next = 1'b0;
        status_next   = rpfa_pkg::STATUS_OK;
        ex_cnt_we     = 1'b0;
        ex_cnt_waddr  = pg_reg;
        ex_cnt_wdata  = alu_res.count;
        if (is_alloc) begin
            if (stack_empty) begin
                status_next = rpfa_pkg::STATUS_EMPTY;
            end else begin
                page_next    = stk_rd;
                count_next   = rpfa_pkg::COUNT_W'(1);
                free_next    = free_top_reg - rpfa_pkg::FREE_W'(1);
                ex_cnt_we    = 1'b1;
                ex_cnt_waddr = stk_rd;
                ex_cnt_wdata = rpfa_pkg::COUNT_W'(1);
            end
        end else if (is_cnt_op) begin
            if (!in_range) begin
                status_next = rpfa_pkg::STATUS_RANGE;
            end else begin
                count_next    = alu_res.count;
                ex_cnt_we     = 1'b1;
                released_next = push_do;
                if (push_do) begin
                    free_next = free_top_reg + rpfa_pkg::FREE_W'(1);
                end
                if (alu_res.saturated) begin
                    status_next = rpfa_pkg::STATUS_SAT;
                end
            end
        end
    end

    // count table write port: clearing sweep or execute write back
    always_comb begin
        if (state_reg == CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_addr_reg;
            cnt_wdata = '0;
        end else begin
            cnt_we    = exec_go && ex_cnt_we;
            cnt_waddr = ex_cnt_waddr;
            cnt_wdata = ex_cnt_wdata;
        end
    end

    assign stk_we = exec_go && push_do;

    // ------------------------------------------------------------------
    // Sequencer and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= CLEAR;
            clr_addr_reg   <= '0;
            free_top_reg   <= '0;
            first_page_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                first_page_reg <= cfg_data;
            end

            // a result drained in the cycle EXEC completes is replaced below
            if (m_valid_reg && m_ready && !exec_go) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + rpfa_pkg::PAGE_W'(1);
                    if (clr_addr_reg == rpfa_pkg::PAGE_W'(rpfa_pkg::NUM_PAGES - 1)) begin
                        state_reg <= IDLE;
                    end
                end
                IDLE: begin
                    if (s_fire) begin
                        state_reg <= EXEC;
                    end
                end
                EXEC: begin
                    if (exec_go) begin
                        state_reg    <= IDLE;
                        free_top_reg <= free_next;
                        m_valid_reg  <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= CLEAR;
                end
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg <= s_operation;
            pg_reg <= s_page_number;
        end
        if (exec_go) begin
            m_page_reg     <= page_next;
            m_count_reg    <= count_next;
            m_free_reg     <= free_next;
            m_released_reg <= released_next;
            m_status_reg   <= status_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_page_out   = m_page_reg;
    assign m_count_out  = m_count_reg;
    assign m_free_pages = m_free_reg;
    assign m_released   = m_released_reg;
    assign m_status     = m_status_reg;

`ifndef ASSERT_OFF
    // stack depth never exceeds the pool size
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_top_reg <= FULL_LEVEL)
        else $error("free stack depth above pool size");

    // stack depth only moves when an operation completes
    a_top_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(free_top_reg)) |-> $past(exec_go))
        else $error("free stack depth changed outside execute");

    // a released page always reports ok
    a_rel_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_released_reg) |-> (m_status_reg == rpfa_pkg::STATUS_OK))
        else $error("released with error status");

    // failed alloc hands out nothing
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == rpfa_pkg::STATUS_EMPTY)) |->
        ((m_page_reg == '0) && (m_count_reg == '0)))
        else $error("empty alloc returned a page");
`endif

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: page frame allocator with reference counts
// Runs directed and random operation sequences through the allocator and
// predicts every result from a behavioral copy of the free stack, the count
// table and first_page. Both handshake sides idle at random in phases one and two.
// ----------------------------------------------------------------------------
module testbench;

    // codes the block does not define; they must change nothing
    localparam logic [rpfa_pkg::OP_W-1:0]   OP_UNUSED6 = 3'd6;
    localparam logic [rpfa_pkg::OP_W-1:0]   OP_UNUSED7 = 3'd7;
    localparam logic [rpfa_pkg::PAGE_W-1:0] PAGE_MAX   = 12'hFFF;

    typedef struct packed {
        logic [rpfa_pkg::PAGE_W-1:0]   page;
        logic [rpfa_pkg::COUNT_W-1:0]  count;
        logic [rpfa_pkg::FREE_W-1:0]   free;
        logic                          released;
        logic [rpfa_pkg::STATUS_W-1:0] status;
    } alloc_result_t;

    // every input starts at a known value; reset is held from time zero
    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [rpfa_pkg::OP_W-1:0]       s_operation = rpfa_pkg::OP_GET;
    logic [rpfa_pkg::PAGE_W-1:0]     s_page_number = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [rpfa_pkg::PAGE_W-1:0]     m_page_out;
    logic [rpfa_pkg::COUNT_W-1:0]    m_count_out;
    logic [rpfa_pkg::FREE_W-1:0]     m_free_pages;
    logic                            m_released;
    logic [rpfa_pkg::STATUS_W-1:0]   m_status;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rpfa_pkg::PAGE_W-1:0]     cfg_data = '0;

    // predicted allocator state
    logic [rpfa_pkg::PAGE_W-1:0]     free_stack_copy [rpfa_pkg::NUM_PAGES];
    logic [rpfa_pkg::COUNT_W-1:0]    ref_count_copy [rpfa_pkg::NUM_PAGES];
    logic [rpfa_pkg::FREE_W-1:0]     free_depth = '0;
    logic [rpfa_pkg::PAGE_W-1:0]     first_page_copy = '0;

    alloc_result_t                   pending_results[$];   // one per accepted transaction
    logic [rpfa_pkg::PAGE_W-1:0]     handed_out[$];        // pages recently returned by alloc
    int unsigned                     mismatches = 0;
    int unsigned                     send_idle_pct = 0;
    int unsigned                     recv_idle_pct = 0;

    refcounted_page_frame_allocator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_page_number (s_page_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_page_out    (m_page_out),
        .m_count_out   (m_count_out),
        .m_free_pages  (m_free_pages),
        .m_released    (m_released),
        .m_status      (m_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // generous bound: reset clearing pass and all traffic at the worst idle
    // ratios fit many times over
    initial begin
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // a push onto a full stack is dropped
    function automatic logic push_free_page(input logic [rpfa_pkg::PAGE_W-1:0] pg);
        if (free_depth == rpfa_pkg::FREE_W'(rpfa_pkg::NUM_PAGES)) return 1'b0;
        free_stack_copy[free_depth[rpfa_pkg::PAGE_W-1:0]] = pg;
        free_depth++;
        return 1'b1;
    endfunction

    function automatic alloc_result_t apply_page_op(
        input logic [rpfa_pkg::OP_W-1:0]   op,
        input logic [rpfa_pkg::PAGE_W-1:0] pg
    );
        alloc_result_t                r;
        logic [rpfa_pkg::COUNT_W-1:0] c;
        r = '0;
        if (op == rpfa_pkg::OP_ALLOC) begin
            if (free_depth == '0) begin
                r.status = rpfa_pkg::STATUS_EMPTY;
            end else begin
                free_depth--;
                r.page = free_stack_copy[free_depth[rpfa_pkg::PAGE_W-1:0]];
                ref_count_copy[r.page] = rpfa_pkg::COUNT_W'(1);
                r.count = rpfa_pkg::COUNT_W'(1);
                handed_out.push_back(r.page);
                if (handed_out.size() > 16) void'(handed_out.pop_front());
            end
        end else if (op <= rpfa_pkg::OP_DONATE) begin
            // 12-bit page numbers can never reach NUM_PAGES, so only the
            // lower bound matters
            if (pg < first_page_copy) begin
                r.status = rpfa_pkg::STATUS_RANGE;
            end else begin
                c = ref_count_copy[pg];
                case (op)
                    rpfa_pkg::OP_FREE: begin
                        if (c == '0) r.released = push_free_page(pg);
                        else c--;
                    end
                    rpfa_pkg::OP_INC: begin
                        if (c == rpfa_pkg::COUNT_MAX) r.status = rpfa_pkg::STATUS_SAT;
                        else c++;
                    end
                    rpfa_pkg::OP_DEC: begin
                        if (c != '0) c--;
                    end
                    rpfa_pkg::OP_DONATE: begin
                        if (c == '0) r.released = push_free_page(pg);
                        c = '0;
                    end
                    default: ;
                endcase
                ref_count_copy[pg] = c;
                r.count = c;
            end
        end
        r.free = free_depth;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random m_ready, each accepted transaction checked in order
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        alloc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing pending");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("page_out", 32'(want.page), 32'(m_page_out));
                check_field("count_out", 32'(want.count), 32'(m_count_out));
                check_field("free_pages", 32'(want.free), 32'(m_free_pages));
                check_field("released", 32'(want.released), 32'(m_released));
                check_field("status", 32'(want.status), 32'(m_status));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Returns in the time step of acceptance with s_valid still high; the next
    // call either drops it (gap) or replaces the payload, so a transaction is
    // never taken twice and s_valid never sees two updates in one step.
    task automatic send_op(input logic [rpfa_pkg::OP_W-1:0]   op,
                           input logic [rpfa_pkg::PAGE_W-1:0] pg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_page_number <= pg;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_page_op(op, pg));
    endtask

    // drain: all results back, then a few quiet cycles
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_first_page(input logic [rpfa_pkg::PAGE_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        first_page_copy = value;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // empty stack, both ends of the page range, donate and pop order
    task automatic test_basic_ops();
        send_op(rpfa_pkg::OP_ALLOC, PAGE_MAX);     // nothing donated yet
        send_op(rpfa_pkg::OP_GET, 12'd0);
        send_op(rpfa_pkg::OP_GET, PAGE_MAX);
        send_op(rpfa_pkg::OP_DONATE, PAGE_MAX);
        send_op(rpfa_pkg::OP_DONATE, 12'd0);
        send_op(rpfa_pkg::OP_DONATE, 12'd1);
        send_op(rpfa_pkg::OP_ALLOC, 12'd0);        // last in, first out: page 1
        send_op(rpfa_pkg::OP_INC, 12'd1);
        send_op(rpfa_pkg::OP_DEC, 12'd1);
    endtask

    // free decrements a live count, dec stops at zero, donate of a live page
    task automatic test_count_rules();
        send_op(rpfa_pkg::OP_FREE, 12'd1);         // count 1 -> 0, no push
        send_op(rpfa_pkg::OP_DEC, 12'd1);          // stays at zero
        send_op(rpfa_pkg::OP_FREE, 12'd1);         // now pushed
        send_op(rpfa_pkg::OP_ALLOC, PAGE_MAX);
        send_op(rpfa_pkg::OP_INC, 12'd1);
        send_op(rpfa_pkg::OP_DONATE, 12'd1);       // live page: zeroed, not pushed
        send_op(rpfa_pkg::OP_DONATE, 12'd1);       // zero count: pushed
    endtask

    task automatic test_unused_codes();
        send_op(OP_UNUSED6, PAGE_MAX);
        send_op(OP_UNUSED7, 12'd0);
    endtask

    // first_page at both extremes and in the middle
    task automatic test_page_range();
        write_first_page(PAGE_MAX);
        send_op(rpfa_pkg::OP_GET, 12'd4094);
        send_op(rpfa_pkg::OP_FREE, 12'd0);
        send_op(rpfa_pkg::OP_INC, PAGE_MAX);
        send_op(rpfa_pkg::OP_ALLOC, 12'd0);        // alloc ignores the range
        send_op(rpfa_pkg::OP_DONATE, 12'd2048);
        write_first_page(12'd2048);
        send_op(rpfa_pkg::OP_DONATE, 12'd2047);
        send_op(rpfa_pkg::OP_DONATE, 12'd2048);
        write_first_page(12'd0);
    endtask

    // count climbs to its maximum, one more inc is refused
    task automatic test_saturation(input logic [rpfa_pkg::PAGE_W-1:0] pg);
        send_op(rpfa_pkg::OP_DONATE, pg);
        repeat (int'(rpfa_pkg::COUNT_MAX)) send_op(rpfa_pkg::OP_INC, pg);
        send_op(rpfa_pkg::OP_INC, pg);
        send_op(rpfa_pkg::OP_GET, pg);
        send_op(rpfa_pkg::OP_DEC, pg);
    endtask

    // Mostly lifetimes of a few hot pages and of pages alloc handed out,
    // with some noise anywhere in the page space and below first_page.
    task automatic run_random_ops(input int n);
        logic [rpfa_pkg::OP_W-1:0]   op;
        logic [rpfa_pkg::PAGE_W-1:0] pg;
        int                          pick;
        int                          hot_base;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 20)      op = rpfa_pkg::OP_ALLOC;
            else if (pick < 38) op = rpfa_pkg::OP_FREE;
            else if (pick < 55) op = rpfa_pkg::OP_INC;
            else if (pick < 66) op = rpfa_pkg::OP_DEC;
            else if (pick < 76) op = rpfa_pkg::OP_GET;
            else if (pick < 95) op = rpfa_pkg::OP_DONATE;
            else                op = $urandom_range(1) ? OP_UNUSED6 : OP_UNUSED7;
            hot_base = (first_page_copy > rpfa_pkg::NUM_PAGES - 8) ?
                       rpfa_pkg::NUM_PAGES - 8 : int'(first_page_copy);
            pick = $urandom_range(99);
            if (pick < 10)
                pg = rpfa_pkg::PAGE_W'($urandom);
            else if (pick < 16 && first_page_copy != '0)
                pg = rpfa_pkg::PAGE_W'($urandom_range(first_page_copy - 1));
            else if (pick < 50 && handed_out.size() != 0)
                pg = handed_out[$urandom_range(handed_out.size() - 1)];
            else
                pg = rpfa_pkg::PAGE_W'(hot_base + int'($urandom_range(7)));
            send_op(op, pg);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (ref_count_copy[i]) ref_count_copy[i] = '0;

        // synchronous reset, then the block clears its count table with
        // s_ready low; send_op simply waits that out
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // phase one: sender idles rarely, receiver often
        send_idle_pct = 18;
        recv_idle_pct = 72;
        test_basic_ops();
        test_count_rules();
        test_unused_codes();
        test_page_range();
        run_random_ops(90);

        // phase two: the other way round, first_page somewhere in the middle
        send_idle_pct = 72;
        recv_idle_pct = 18;
        write_first_page(rpfa_pkg::PAGE_W'($urandom_range(1, 4000)));
        test_saturation(first_page_copy + 12'd3);
        run_random_ops(90);

        // phase three: back to back transactions in both directions
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_first_page(rpfa_pkg::PAGE_W'($urandom_range(1, 1023)));
        run_random_ops(90);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
